// File: design/ictf_pkg.sv
// Shared types, constants and functions of the complementary tilt filter.
package ictf_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int FRAC_BITS_DEF    = 16;

    localparam int ANG_Q  = 24;
    localparam int GUARD  = 14;
    localparam int CW     = 34;                 // CORDIC datapath width
    localparam int SQ_W   = 32 + 2 * GUARD;     // radicand width
    localparam int RT_W   = SQ_W / 2;           // root width

    localparam int               RATE_DEN  = 131;
    localparam int               INC_DEN   = 131000;
    localparam int               RATE_HALF = 65;
    localparam int               INC_HALF  = 65500;
    localparam logic [15:0]      ALPHA_RST = 16'd64225;

    localparam logic [63:0] DEG_PER_RAD_Q24 = 64'd961263669;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_LOAD,
        ST_ITER,
        ST_CORD,
        ST_BLEND,
        ST_ADD
    } t_state;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } t_cvec;

    // atan(2^-i) in degrees, Q.24
    function automatic logic signed [CW-1:0] atan_entry(input int unsigned i);
        logic [63:0] v;
        case (i)
            0: v = 64'd754974720;
            1: v = 64'd445687602;
            2: v = 64'd235489088;
            3: v = 64'd119537938;
            4: v = 64'd60000934;
            5: v = 64'd30029717;
            6: v = 64'd15018523;
            7: v = 64'd7509720;
            8: v = 64'd3754917;
            9: v = 64'd1877466;
            default: v = (DEG_PER_RAD_Q24 + (64'd1 << (i - 1))) >> i;
        endcase
        return v[CW-1:0];
    endfunction

endpackage

// File: design/ictf_div.sv
// Divider by a constant: forms each 8-bit quotient digit by reciprocal multiply.
module ictf_div #(
    parameter int NW  = 64,
    parameter int DEN = 131
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    output logic          o_busy,
    output logic [NW-1:0] o_quo
);

    localparam int DG    = 8;                   // quotient digit width
    localparam int NP    = ((NW + DG - 1) / DG) * DG;
    localparam int STEPS = 2 * NP / DG;
    localparam int CNT_W = $clog2(STEPS + 1);
    localparam int DW    = $clog2(DEN);         // remainder width
    localparam int TW    = DW + DG;             // partial dividend width
    localparam int SH    = TW + DW;
    localparam int MW    = TW + 1;
    localparam longint unsigned RECIP = ((64'd1 << SH) + 64'(DEN) - 64'd1) / 64'(DEN);
    localparam logic [MW-1:0] M = MW'(RECIP);

    logic [CNT_W-1:0] r_cnt;
    logic             r_ph;
    logic [NP-1:0]    r_n;
    logic [NP-1:0]    r_q;
    logic [DW-1:0]    r_rem;
    logic [TW-1:0]    r_t;
    logic [DG-1:0]    r_qd;

    logic [TW-1:0]    w_t;
    logic [TW+MW-1:0] w_prod;
    logic [TW-1:0]    w_qden;

    // partial dividend stays below DEN * 2^DG, so the digit is exact
    always_comb begin
        w_t    = {r_rem, r_n[NP-1 -: DG]};
        w_prod = (TW+MW)'(w_t) * (TW+MW)'(M);
        w_qden = TW'(r_qd) * TW'(DEN);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(STEPS);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // the first phase forms a digit, the second takes back its multiple of the divisor
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ph  <= 1'b0;
            r_n   <= NP'(i_num);
            r_q   <= '0;
            r_rem <= '0;
        end else if (r_cnt != '0) begin
            r_ph <= !r_ph;
            if (!r_ph) begin
                r_t  <= w_t;
                r_qd <= w_prod[SH +: DG];
                r_n  <= {r_n[NP-DG-1:0], {DG{1'b0}}};
            end else begin
                r_rem <= DW'(r_t - w_qden);
                r_q   <= {r_q[NP-DG-1:0], r_qd};
            end
        end
    end

    assign o_busy = r_cnt != '0;
    assign o_quo  = r_q[NW-1:0];

endmodule

// File: design/ictf_sqrt.sv
// Digit-by-digit integer square root, one root bit per cycle.
module ictf_sqrt (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [ictf_pkg::SQ_W-1:0] i_n,
    output logic                      o_busy,
    output logic [ictf_pkg::RT_W-1:0] o_root
);
    import ictf_pkg::*;

    localparam int CNT_W = $clog2(RT_W + 1);

    logic [CNT_W-1:0] r_cnt;
    logic [SQ_W-1:0]  r_n;
    logic [RT_W:0]    r_rem;
    logic [RT_W-1:0]  r_root;

    logic [RT_W+2:0]  w_rem;
    logic [RT_W+2:0]  w_trial;
    logic             w_ge;

    always_comb begin
        w_rem   = {r_rem, r_n[SQ_W-1 -: 2]};
        w_trial = {1'b0, r_root, 2'b01};
        w_ge    = w_rem >= w_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(RT_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n    <= i_n;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_cnt != '0) begin
            r_n    <= {r_n[SQ_W-3:0], 2'b00};
            r_rem  <= w_ge ? (RT_W+1)'(w_rem - w_trial) : w_rem[RT_W:0];
            r_root <= {r_root[RT_W-2:0], w_ge};
        end
    end

    assign o_busy = r_cnt != '0;
    assign o_root = r_root;

endmodule

// File: design/ictf_cordic_cell.sv
// One vectoring CORDIC rotation stage with its output register.
module ictf_cordic_cell #(
    parameter int IDX = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  ictf_pkg::t_cvec i_vec,
    output logic            o_valid,
    output ictf_pkg::t_cvec o_vec
);
    import ictf_pkg::*;

    localparam logic signed [CW-1:0] ATAN = atan_entry(IDX);

    logic            r_valid;
    t_cvec           r_vec;
    t_cvec           n_vec;
    logic signed [CW-1:0] w_dx, w_dy;

    always_comb begin
        w_dx  = i_vec.y >>> IDX;
        w_dy  = i_vec.x >>> IDX;
        n_vec = i_vec;
        // zero residue: leave the vector alone
        if (i_vec.y > 0) begin
            n_vec.x = i_vec.x + w_dx;
            n_vec.y = i_vec.y - w_dy;
            n_vec.z = i_vec.z + ATAN;
        end else if (i_vec.y < 0) begin
            n_vec.x = i_vec.x - w_dx;
            n_vec.y = i_vec.y + w_dy;
            n_vec.z = i_vec.z - ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_vec <= n_vec;
        end
    end

    assign o_valid = r_valid;
    assign o_vec   = r_vec;

endmodule

// File: design/imu_complementary_tilt_filter.sv
// Top level of the accelerometer/gyro complementary tilt filter.
//
// Input channel i_in_valid/o_in_ready carries one raw sample per request:
// accelerometer X/Y/Z, gyro Y and a millisecond timestamp. Output channel
// o_out_valid/i_out_ready returns one request per sample: the filtered tilt
// angle and the gyro rate, both signed Q.FRAC_BITS, in degrees and degrees per second.
// i_cfg_we/i_cfg_data writes the gyro weight alpha (unsigned Q0.16).
//
// One sample is processed at a time. From input accept to output valid the
// sample passes the setup states ST_MUL and ST_LOAD, the iterative square
// root (both constant dividers finish inside it), then the vector passes the
// row of CORDIC_STEPS rotation cells, then the angle capture and the blend
// states ST_BLEND and ST_ADD. The next sample may be accepted while a result
// waits in the output register; when the receiver stalls the finished blend
// holds until the output register frees up.
// Reset clears the filtered angle and last timestamp to zero and sets alpha
// to 0.98.
module imu_complementary_tilt_filter #(
    parameter int CORDIC_STEPS = ictf_pkg::CORDIC_STEPS_DEF,
    parameter int FRAC_BITS    = ictf_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [15:0] i_accel_x,
    input  logic signed [15:0] i_accel_y,
    input  logic signed [15:0] i_accel_z,
    input  logic signed [15:0] i_gyro_y,
    input  logic [31:0]        i_time_ms,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_tilt_angle,
    output logic signed [31:0] o_rate_deg,
    input  logic               i_cfg_we,
    input  logic [15:0]        i_cfg_data
);
    import ictf_pkg::*;

    localparam int INC_W  = 48 + FRAC_BITS;
    localparam int RATE_W = 16 + FRAC_BITS;
    localparam int RSH    = ANG_Q - FRAC_BITS;
    localparam logic signed [CW-1:0] RND = (RSH > 0) ? (CW'(1) << (RSH - 1)) : '0;
    localparam int SAT_W  = 96;

    function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
        if (v > SAT_W'(64'sd2147483647)) begin
            return 32'sh7fffffff;
        end else if (v < SAT_W'(-64'sd2147483648)) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    t_state r_state, n_state;

    logic signed [15:0] r_ax, r_ay, r_az, r_gy;
    logic [31:0]        r_delta;
    logic [31:0]        r_last;
    logic signed [31:0] r_filt;
    logic [15:0]        r_alpha;
    logic [31:0]        r_sq;
    logic [47:0]        r_pmag;
    logic               r_pneg;
    logic signed [31:0] r_sum, r_rate, r_acc;
    logic signed [48:0] r_p1;
    logic signed [49:0] r_p2;
    logic               r_out_valid;
    logic signed [31:0] r_out_angle, r_out_rate;

    logic               w_accept, w_start, w_inject, w_free, w_units_busy;
    logic signed [48:0] w_prod;
    logic signed [31:0] w_ay2, w_az2;
    logic [16:0]        w_gmag;
    logic [INC_W-1:0]   w_inc_n, w_inc_q;
    logic [RATE_W-1:0]  w_rate_n, w_rate_q;
    logic [RT_W-1:0]    w_root;
    logic               w_sqrt_busy, w_inc_busy, w_rate_busy;
    logic signed [INC_W:0]   w_inc_s;
    logic signed [INC_W+1:0] w_sum;
    logic signed [RATE_W:0]  w_rate_s;
    logic signed [CW-1:0]    w_zr;
    logic [16:0]        w_beta;
    logic signed [50:0] w_blend;
    logic signed [50:0] w_bsh;

    logic [CORDIC_STEPS:0] w_cv;
    t_cvec                 w_cvec [0:CORDIC_STEPS];

    assign w_accept = i_in_valid && o_in_ready;
    assign w_free   = !r_out_valid || i_out_ready;
    assign w_units_busy = w_sqrt_busy || w_inc_busy || w_rate_busy;

    always_comb begin
        n_state  = r_state;
        w_start  = 1'b0;
        w_inject = 1'b0;
        case (r_state)
            ST_IDLE:  if (i_in_valid) n_state = ST_MUL;
            ST_MUL:   n_state = ST_LOAD;
            ST_LOAD: begin
                w_start = 1'b1;
                n_state = ST_ITER;
            end
            ST_ITER: begin
                if (!w_units_busy) begin
                    w_inject = 1'b1;
                    n_state  = ST_CORD;
                end
            end
            ST_CORD:  if (w_cv[CORDIC_STEPS]) n_state = ST_BLEND;
            ST_BLEND: n_state = ST_ADD;
            ST_ADD:   if (w_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // sample capture and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last  <= '0;
            r_filt  <= '0;
            r_alpha <= ALPHA_RST;
        end else begin
            if (i_cfg_we) begin
                r_alpha <= i_cfg_data;
            end
            if (w_accept) begin
                r_last <= i_time_ms;
            end
            if (r_state == ST_ADD && w_free) begin
                r_filt <= sat32(SAT_W'(w_bsh));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ax    <= i_accel_x;
            r_ay    <= i_accel_y;
            r_az    <= i_accel_z;
            r_gy    <= i_gyro_y;
            r_delta <= i_time_ms - r_last;
        end
    end

    // products ahead of the iterative units
    assign w_prod = $signed(r_gy) * $signed({1'b0, r_delta});
    assign w_ay2  = r_ay * r_ay;
    assign w_az2  = r_az * r_az;
    assign w_gmag = r_gy[15] ? (17'd0 - {r_gy[15], r_gy}) : {1'b0, r_gy};

    always_ff @(posedge i_clk) begin
        if (r_state == ST_MUL) begin
            r_sq   <= $unsigned(w_ay2) + $unsigned(w_az2);
            r_pneg <= w_prod[48];
            r_pmag <= w_prod[48] ? 48'(-w_prod) : w_prod[47:0];
        end
    end

    // round-half-away division folded into one floor division
    assign w_inc_n  = {r_pmag, {FRAC_BITS{1'b0}}} + INC_W'(INC_HALF);
    assign w_rate_n = {w_gmag[15:0], {FRAC_BITS{1'b0}}} + RATE_W'(RATE_HALF);

    ictf_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_n     ({r_sq, {(2 * GUARD){1'b0}}}),
        .o_busy  (w_sqrt_busy),
        .o_root  (w_root)
    );

    ictf_div #(.NW(INC_W), .DEN(INC_DEN)) u_div_inc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_num   (w_inc_n),
        .o_busy  (w_inc_busy),
        .o_quo   (w_inc_q)
    );

    ictf_div #(.NW(RATE_W), .DEN(RATE_DEN)) u_div_rate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_num   (w_rate_n),
        .o_busy  (w_rate_busy),
        .o_quo   (w_rate_q)
    );

    assign w_inc_s  = r_pneg ? -$signed({1'b0, w_inc_q}) : $signed({1'b0, w_inc_q});
    assign w_sum    = (INC_W+2)'(r_filt) + (INC_W+2)'(w_inc_s);
    assign w_rate_s = r_gy[15] ? -$signed({1'b0, w_rate_q}) : $signed({1'b0, w_rate_q});

    always_ff @(posedge i_clk) begin
        if (w_inject) begin
            r_sum  <= sat32(SAT_W'(w_sum));
            r_rate <= sat32(SAT_W'(w_rate_s));
        end
    end

    // CORDIC vectoring row
    assign w_cv[0]     = w_inject;
    assign w_cvec[0].x = CW'(w_root);
    assign w_cvec[0].y = CW'(r_ax) <<< GUARD;
    assign w_cvec[0].z = '0;

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
        ictf_cordic_cell #(.IDX(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_cv[g]),
            .i_vec   (w_cvec[g]),
            .o_valid (w_cv[g+1]),
            .o_vec   (w_cvec[g+1])
        );
    end

    assign w_zr = (w_cvec[CORDIC_STEPS].z + RND) >>> RSH;

    always_ff @(posedge i_clk) begin
        if (r_state == ST_CORD && w_cv[CORDIC_STEPS]) begin
            r_acc <= w_zr[31:0];
        end
    end

    // blend
    assign w_beta = 17'd65536 - {1'b0, r_alpha};

    always_ff @(posedge i_clk) begin
        if (r_state == ST_BLEND) begin
            r_p1 <= $signed({1'b0, r_alpha}) * r_sum;
            r_p2 <= $signed({1'b0, w_beta}) * r_acc;
        end
    end

    assign w_blend = 51'(r_p1) + 51'(r_p2) + 51'sd32768;
    assign w_bsh   = w_blend >>> 16;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_ADD && w_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_ADD && w_free) begin
            r_out_angle <= sat32(SAT_W'(w_bsh));
            r_out_rate  <= r_rate;
        end
    end

    assign o_in_ready   = r_state == ST_IDLE;
    assign o_out_valid  = r_out_valid;
    assign o_tilt_angle = r_out_angle;
    assign o_rate_deg   = r_out_rate;

    a_one_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_cv))
        else $error("more than one vector in the CORDIC row");

    a_row_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cv[CORDIC_STEPS] |-> r_state == ST_CORD)
        else $error("CORDIC result outside the CORDIC wait");

    a_idle_units: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_IDLE |-> !w_units_busy)
        else $error("iterative unit busy while idle");

    a_accept_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state == ST_MUL && !w_units_busy)
        else $error("accept did not start a new request");

endmodule
